// File: hw/rtl/rcq_pkg.sv
// Shared constants, opcodes and status types of the resizing circular queue.
package rcq_pkg;

   localparam int INITIAL_CAPACITY = 5;
   localparam int MAX_DOUBLINGS    = 6;
   localparam int DATA_WIDTH       = 32;

   localparam int MAX_CAPACITY = INITIAL_CAPACITY << MAX_DOUBLINGS;
   localparam int ADDR_W       = $clog2(MAX_CAPACITY);
   localparam int CNT_W        = $clog2(MAX_CAPACITY + 1);
   localparam int SUM_W        = ADDR_W + 1;

   localparam int VALUE_W = 32;
   localparam int OCC_W   = 9;

   localparam logic OP_ENQ = 1'b0;
   localparam logic OP_DEQ = 1'b1;

   typedef logic [DATA_WIDTH-1:0] word_type;

   typedef struct packed {
      logic             deq_ok;
      logic             underflow;
      logic             overflow;
      logic [OCC_W-1:0] occupancy;
      logic [OCC_W-1:0] capacity_now;
      logic             is_empty;
      logic             is_full;
   } stat_type;

endpackage

// File: hw/rtl/rcq_if.sv
// Request and response channel interfaces of the resizing circular queue.
interface rcq_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   logic signed [31:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

interface rcq_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] data_out;
   logic               underflow;
   logic               overflow;
   logic [8:0]         occupancy;
   logic [8:0]         capacity_now;
   logic               is_empty;
   logic               is_full;

   modport source (output valid, output data_out, output underflow, output overflow,
                   output occupancy, output capacity_now, output is_empty, output is_full,
                   input ready);
   modport sink   (input valid, input data_out, input underflow, input overflow,
                   input occupancy, input capacity_now, input is_empty, input is_full,
                   output ready);
endinterface

// File: hw/rtl/rcq_ram.sv
// Simple dual-port RAM with registered read data.
module rcq_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 320,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// File: hw/rtl/rcq_ctrl.sv
// Queue pointer, count and capacity control with storage access generation.
module rcq_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic                      op,
   input  logic signed [31:0]        value,
   output logic                      wr_en,
   output logic [rcq_pkg::ADDR_W-1:0] wr_addr,
   output rcq_pkg::word_type         wr_data,
   output logic                      rd_en,
   output logic [rcq_pkg::ADDR_W-1:0] rd_addr,
   output rcq_pkg::stat_type         stat
);

   localparam logic [rcq_pkg::CNT_W-1:0] CAP_INIT =
      rcq_pkg::CNT_W'(rcq_pkg::INITIAL_CAPACITY);
   localparam logic [rcq_pkg::CNT_W-1:0] CAP_MAX =
      rcq_pkg::CNT_W'(rcq_pkg::MAX_CAPACITY);

   logic [rcq_pkg::ADDR_W-1:0] head_ff, head_in;
   logic [rcq_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [rcq_pkg::CNT_W-1:0]  cap_ff, cap_in;
   logic                       full, at_max;

   function automatic logic [rcq_pkg::ADDR_W-1:0] ring_add(
      input logic [rcq_pkg::ADDR_W-1:0] base,
      input logic [rcq_pkg::CNT_W-1:0]  off
   );
      logic [rcq_pkg::SUM_W-1:0] s;
      s = rcq_pkg::SUM_W'(base) + rcq_pkg::SUM_W'(off);
      if (s >= rcq_pkg::SUM_W'(rcq_pkg::MAX_CAPACITY)) begin
         s = s - rcq_pkg::SUM_W'(rcq_pkg::MAX_CAPACITY);
      end
      return s[rcq_pkg::ADDR_W-1:0];
   endfunction

   assign full   = count_ff >= cap_ff;
   assign at_max = cap_ff >= CAP_MAX;

   always_comb begin
      head_in        = head_ff;
      count_in       = count_ff;
      cap_in         = cap_ff;
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      wr_addr        = ring_add(head_ff, count_ff);
      rd_addr        = head_ff;
      wr_data        = rcq_pkg::DATA_WIDTH'($unsigned(value));
      stat.deq_ok    = 1'b0;
      stat.underflow = 1'b0;
      stat.overflow  = 1'b0;
      case (op)
         rcq_pkg::OP_ENQ: begin
            if (full && at_max) begin
               stat.overflow = 1'b1;
            end else begin
               if (full) begin
                  cap_in = cap_ff << 1;
               end
               wr_en    = accept;
               count_in = count_ff + 1'b1;
            end
         end
         rcq_pkg::OP_DEQ: begin
            if (count_ff == '0) begin
               stat.underflow = 1'b1;
            end else begin
               rd_en       = accept;
               stat.deq_ok = 1'b1;
               count_in    = count_ff - 1'b1;
               head_in     = ring_add(head_ff, rcq_pkg::CNT_W'(1));
               if (count_in == '0) begin
                  head_in = '0;
               end else if (cap_ff > CAP_INIT && count_in == (cap_ff >> 1)) begin
                  cap_in = cap_ff >> 1;
               end
            end
         end
         default: begin
            stat.underflow = 1'b0;
         end
      endcase
      stat.occupancy    = rcq_pkg::OCC_W'(count_in);
      stat.capacity_now = rcq_pkg::OCC_W'(cap_in);
      stat.is_empty     = count_in == '0;
      stat.is_full      = count_in == cap_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         cap_ff   <= CAP_INIT;
      end else if (accept) begin
         head_ff  <= head_in;
         count_ff <= count_in;
         cap_ff   <= cap_in;
      end
   end

   a_count_in_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cap_ff) else $error("count exceeds capacity");

   a_cap_bounds: assert property (@(posedge clock) disable iff (reset)
      cap_ff >= CAP_INIT && cap_ff <= CAP_MAX) else $error("capacity out of range");

   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      accept |-> $countones({stat.deq_ok, stat.underflow, stat.overflow}) <= 1)
      else $error("conflicting status flags");

   a_empty_rewind: assert property (@(posedge clock) disable iff (reset)
      accept && op == rcq_pkg::OP_DEQ && count_ff == rcq_pkg::CNT_W'(1)
      |=> head_ff == '0 && count_ff == '0) else $error("head not rewound on empty");

   a_drop_holds: assert property (@(posedge clock) disable iff (reset)
      accept && stat.overflow |=> $stable(count_ff) && $stable(cap_ff))
      else $error("dropped word changed state");

endmodule

// File: hw/rtl/resizing_circular_queue_core.sv
// Resizing circular queue: top level with storage, control and response stages.
// A result is registered in the s1 stage and then in the output register before it appears.
// Throughput: one request word per cycle while results are taken; the response holding
// register lets a new word enter while the previous result still waits to be taken.
// Storage read data is registered, which sets the extra stage before the output.
// Reset clears head, count and the response stages and sets capacity to 5;
// storage is not cleared.
module resizing_circular_queue_core (
   input  logic         clock,
   input  logic         reset,
   rcq_req_if.sink      req_port,
   rcq_rsp_if.source    rsp_port
);

   logic                        accept;
   logic                        wr_en, rd_en;
   logic [rcq_pkg::ADDR_W-1:0]  wr_addr, rd_addr;
   rcq_pkg::word_type           wr_data, rd_data;
   rcq_pkg::stat_type           stat;

   logic                        s1_valid_ff;
   rcq_pkg::stat_type           s1_stat_ff;
   logic                        s1_advance;

   logic                        out_valid_ff;
   rcq_pkg::stat_type           out_stat_ff;
   logic signed [31:0]          out_data_ff, out_data_in;

   assign s1_advance     = s1_valid_ff && (!out_valid_ff || rsp_port.ready);
   assign req_port.ready = !s1_valid_ff || s1_advance;
   assign accept         = req_port.valid && req_port.ready;

   rcq_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .op      (req_port.op),
      .value   (req_port.value),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .stat    (stat)
   );

   rcq_ram #(
      .WIDTH  (rcq_pkg::DATA_WIDTH),
      .DEPTH  (rcq_pkg::MAX_CAPACITY),
      .ADDR_W (rcq_pkg::ADDR_W)
   ) u_ram (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_stat_ff <= stat;
      end
   end

   always_comb begin
      out_data_in = '0;
      if (s1_stat_ff.deq_ok) begin
         out_data_in = 32'($unsigned(rd_data));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         out_stat_ff <= s1_stat_ff;
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_port.valid        = out_valid_ff;
   assign rsp_port.data_out     = out_data_ff;
   assign rsp_port.underflow    = out_stat_ff.underflow;
   assign rsp_port.overflow     = out_stat_ff.overflow;
   assign rsp_port.occupancy    = out_stat_ff.occupancy;
   assign rsp_port.capacity_now = out_stat_ff.capacity_now;
   assign rsp_port.is_empty     = out_stat_ff.is_empty;
   assign rsp_port.is_full      = out_stat_ff.is_full;

endmodule
